[rtl/dros_pkg.sv]
// ----------------------------------------------------------------------------
// dros_pkg
// Shared types, widths and helpers of the depth ray occupancy sampler.
// ----------------------------------------------------------------------------
package dros_pkg;

    localparam int PX_W       = 10;
    localparam int PY_W       = 9;
    localparam int DEPTH_W    = 16;
    localparam int COL_W      = 8;
    localparam int PIDX_W     = 4;
    localparam int POSE_W     = 32;
    localparam int POSE_N     = 12;
    localparam int CENTRE_W   = 14;
    localparam int INVF_W     = 24;
    localparam int RAY_W      = 16;
    localparam int RATIO_W    = 31;
    localparam int WORLD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_USER_W = 2;

    localparam int FRAME_WIDTH_DEF     = 640;
    localparam int MAX_STEPS_DEF       = 64;
    localparam int DEPTH_UNITS_DEF     = 1000;

    localparam logic [POSE_W-1:0] Q_ONE = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_X    = 3'd0,
        CFG_CENTRE_Y    = 3'd1,
        CFG_INV_FOCAL_X = 3'd2,
        CFG_INV_FOCAL_Y = 3'd3,
        CFG_RAY_START   = 3'd4,
        CFG_RAY_STEP    = 3'd5,
        CFG_RAY_MAX     = 3'd6,
        CFG_DOWNSAMPLE  = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_POSE  = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MOD,
        FS_MUL,
        FS_RND,
        FS_LAUNCH
    } front_state_t;

    typedef struct packed {
        logic [CENTRE_W-1:0] centre_x;
        logic [CENTRE_W-1:0] centre_y;
        logic [INVF_W-1:0]   inv_focal_x;
        logic [INVF_W-1:0]   inv_focal_y;
        logic [RAY_W-1:0]    ray_start;
        logic [RAY_W-1:0]    ray_step;
        logic [RAY_W-1:0]    ray_max;
        logic [RAY_W-1:0]    downsample_factor;
    } cfg_t;

    typedef struct packed {
        logic                pad;
        logic [POSE_W-1:0]   pose_value;
        logic [PIDX_W-1:0]   pose_index;
        logic [COL_W-1:0]    blue;
        logic [COL_W-1:0]    green;
        logic [COL_W-1:0]    red;
        logic [DEPTH_W-1:0]  depth;
        logic [PY_W-1:0]     pixel_y;
        logic [PX_W-1:0]     pixel_x;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]    out_blue;
        logic [COL_W-1:0]    out_green;
        logic [COL_W-1:0]    out_red;
        logic [WORLD_W-1:0]  world_z;
        logic [WORLD_W-1:0]  world_y;
        logic [WORLD_W-1:0]  world_x;
    } out_item_t;

    typedef logic [POSE_N-1:0][POSE_W-1:0] pose_mat_t;

    typedef struct packed {
        logic signed [RATIO_W-1:0] ratio_x;
        logic signed [RATIO_W-1:0] ratio_y;
        logic [DEPTH_W-1:0]        depth;
        logic [COL_W-1:0]          red;
        logic [COL_W-1:0]          green;
        logic [COL_W-1:0]          blue;
    } ray_job_t;

    typedef struct packed {
        logic              occupied;
        logic              colour_valid;
        logic              last;
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
    } side_t;

    typedef struct packed {
        logic [RAY_W-1:0]          d;
        logic signed [RATIO_W-1:0] ratio_x;
        logic signed [RATIO_W-1:0] ratio_y;
        side_t                     side;
    } sample_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic pose_mat_t pose_identity();
        pose_mat_t p;
        p     = '0;
        p[0]  = Q_ONE;
        p[5]  = Q_ONE;
        p[10] = Q_ONE;
        return p;
    endfunction

endpackage

[rtl/dros_mod_unit.sv]
// ----------------------------------------------------------------------------
// dros_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dros_mod_unit #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic             is_zero
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   trial;

    assign trial   = {rem_reg, num_reg[NUM_W-1]};
    assign done    = done_reg;
    assign is_zero = (rem_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            if (trial >= {1'b0, den})
                rem_reg <= DEN_W'(trial - {1'b0, den});
            else
                rem_reg <= trial[DEN_W-1:0];
        end
    end

endmodule

[rtl/dros_front.sv]
// ----------------------------------------------------------------------------
// dros_front
// Input intake: pose loads, dead pixel and downsample filter, ray ratios.
// ----------------------------------------------------------------------------
module dros_front #(
    parameter int FRAME_WIDTH = dros_pkg::FRAME_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_action,
    input  dros_pkg::in_item_t  in_item,
    input  dros_pkg::cfg_t      cfg,
    input  logic                engine_busy,
    output dros_pkg::pose_mat_t pose,
    output logic                job_launch,
    output dros_pkg::ray_job_t  job
);
    import dros_pkg::*;

    localparam int LIN_MAX = (2**PY_W - 1) * FRAME_WIDTH + 2**PX_W - 1;
    localparam int LIN_W   = $clog2(LIN_MAX + 1);
    localparam int PROD_W  = 39;

    front_state_t state_reg, state_next;
    pose_mat_t    pose_reg;

    logic               accept;
    logic               is_pixel;
    logic               mod_start;
    logic               mod_done;
    logic               mod_zero;
    logic [LIN_W-1:0]   lin;

    logic [PX_W-1:0]    px_reg;
    logic [PY_W-1:0]    py_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [COL_W-1:0]   red_reg, green_reg, blue_reg;

    logic signed [14:0]        du_x, du_y;
    logic signed [INVF_W:0]    inv_x_s, inv_y_s;
    logic signed [PROD_W-1:0]  prod_x_reg, prod_y_reg;
    logic signed [PROD_W-1:0]  adj_x, adj_y;
    logic signed [RATIO_W-1:0] ratio_x_reg, ratio_y_reg;

    assign accept   = in_valid && in_ready;
    assign is_pixel = (action_t'(in_action) == ACT_PIXEL) && (in_item.depth != '0);
    assign lin      = LIN_W'(in_item.pixel_y) * LIN_W'(FRAME_WIDTH) + LIN_W'(in_item.pixel_x);

    dros_mod_unit #(
        .NUM_W (LIN_W),
        .DEN_W (RAY_W)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .num     (lin),
        .den     (cfg.downsample_factor),
        .done    (mod_done),
        .is_zero (mod_zero)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (accept && is_pixel)
                    state_next = (cfg.downsample_factor == '0) ? FS_MUL : FS_MOD;
            end
            FS_MOD:
            begin
                if (mod_done)
                    state_next = mod_zero ? FS_MUL : FS_IDLE;
            end
            FS_MUL:    state_next = FS_RND;
            FS_RND:    state_next = FS_LAUNCH;
            FS_LAUNCH: state_next = FS_IDLE;
            default:   state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == FS_IDLE) && !engine_busy;
        mod_start  = accept && is_pixel && (cfg.downsample_factor != '0);
        job_launch = (state_reg == FS_LAUNCH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            pose_reg  <= pose_identity();
        end
        else
        begin
            state_reg <= state_next;
            if (accept && action_t'(in_action) == ACT_POSE && in_item.pose_index < PIDX_W'(POSE_N))
                pose_reg[in_item.pose_index] <= in_item.pose_value;
        end
    end

    assign du_x    = $signed({1'b0, px_reg, 4'b0}) - $signed({1'b0, cfg.centre_x});
    assign du_y    = $signed({2'b0, py_reg, 4'b0}) - $signed({1'b0, cfg.centre_y});
    assign inv_x_s = $signed({1'b0, cfg.inv_focal_x});
    assign inv_y_s = $signed({1'b0, cfg.inv_focal_y});
    assign adj_x   = prod_x_reg + (prod_x_reg[PROD_W-1] ? 39'sd127 : 39'sd128);
    assign adj_y   = prod_y_reg + (prod_y_reg[PROD_W-1] ? 39'sd127 : 39'sd128);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= in_item.pixel_x;
            py_reg    <= in_item.pixel_y;
            depth_reg <= in_item.depth;
            red_reg   <= in_item.red;
            green_reg <= in_item.green;
            blue_reg  <= in_item.blue;
        end
        if (state_reg == FS_MUL)
        begin
            prod_x_reg <= PROD_W'(du_x) * PROD_W'(inv_x_s);
            prod_y_reg <= PROD_W'(du_y) * PROD_W'(inv_y_s);
        end
        if (state_reg == FS_RND)
        begin
            ratio_x_reg <= adj_x[PROD_W-1:8];
            ratio_y_reg <= adj_y[PROD_W-1:8];
        end
    end

    assign pose          = pose_reg;
    assign job.ratio_x   = ratio_x_reg;
    assign job.ratio_y   = ratio_y_reg;
    assign job.depth     = depth_reg;
    assign job.red       = red_reg;
    assign job.green     = green_reg;
    assign job.blue      = blue_reg;

endmodule

[rtl/dros_seq.sv]
// ----------------------------------------------------------------------------
// dros_seq
// Ray marcher: issues one sample depth per cycle into the point pipeline while it advances.
// ----------------------------------------------------------------------------
module dros_seq #(
    parameter int MAX_STEPS = dros_pkg::MAX_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               launch,
    input  dros_pkg::ray_job_t job,
    input  dros_pkg::cfg_t     cfg,
    input  logic               adv,
    output logic               smp_valid,
    output dros_pkg::sample_t  smp,
    output logic               busy
);
    import dros_pkg::*;

    localparam int N_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    logic             active_reg;
    logic             coloured_reg;
    logic [RAY_W-1:0] d_reg;
    logic [N_W-1:0]   n_reg;
    ray_job_t         job_reg;

    logic [RAY_W:0]   d_sum;
    logic             occ;
    logic             cv;
    logic             last;
    logic             issue;

    assign d_sum = {1'b0, d_reg} + {1'b0, cfg.ray_step};
    assign occ   = d_reg > job_reg.depth;
    assign cv    = occ && !coloured_reg;
    assign last  = (d_sum >= {1'b0, cfg.ray_max}) || (n_reg == N_W'(MAX_STEPS - 1));
    assign issue = active_reg && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            coloured_reg <= 1'b0;
            n_reg        <= '0;
        end
        else if (launch)
        begin
            active_reg   <= cfg.ray_start < cfg.ray_max;
            coloured_reg <= 1'b0;
            n_reg        <= '0;
        end
        else if (issue)
        begin
            coloured_reg <= coloured_reg || occ;
            n_reg        <= n_reg + 1'b1;
            if (last)
                active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            d_reg   <= cfg.ray_start;
            job_reg <= job;
        end
        else if (issue)
            d_reg <= d_sum[RAY_W-1:0];
    end

    assign smp_valid             = active_reg;
    assign busy                  = active_reg;
    assign smp.d                 = d_reg;
    assign smp.ratio_x           = job_reg.ratio_x;
    assign smp.ratio_y           = job_reg.ratio_y;
    assign smp.side.occupied     = occ;
    assign smp.side.colour_valid = cv;
    assign smp.side.last         = last;
    assign smp.side.red          = cv ? job_reg.red : '0;
    assign smp.side.green        = cv ? job_reg.green : '0;
    assign smp.side.blue         = cv ? job_reg.blue : '0;

`ifndef SYNTHESIS
    a_last_ends_ray: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last && !launch) |=> !active_reg)
        else $error("ray still active after last sample");

    a_colour_needs_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && cv) |-> occ)
        else $error("colour on free-space sample");

    a_depth_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (d_reg < cfg.ray_max))
        else $error("sample depth beyond ray max");
`endif

endmodule

[rtl/dros_pipe.sv]
// ----------------------------------------------------------------------------
// dros_pipe
// Eleven-stage point pipeline: depth to z, back-projection, pose transform.
// ----------------------------------------------------------------------------
module dros_pipe #(
    parameter int DEPTH_UNITS_PER_METRE = dros_pkg::DEPTH_UNITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  dros_pkg::sample_t   smp,
    input  dros_pkg::pose_mat_t pose,
    output logic                adv,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output dros_pkg::out_item_t out_item,
    output dros_pkg::side_t     out_side
);
    import dros_pkg::*;

    localparam int          NSTG  = 11;
    localparam logic [48:0] RECIP = (49'd1 << 48) / 49'(DEPTH_UNITS_PER_METRE);
    localparam logic [23:0] M_LO  = RECIP[23:0];
    localparam logic [24:0] M_HI  = RECIP[48:24];
    localparam logic [31:0] HALF  = 32'(DEPTH_UNITS_PER_METRE / 2);
    localparam logic [31:0] DIV   = 32'(DEPTH_UNITS_PER_METRE);

    logic [NSTG-1:0] v_reg;

    // side band and ratios ride along
    side_t                     side_reg [NSTG];
    logic signed [RATIO_W-1:0] rx_reg [5];
    logic signed [RATIO_W-1:0] ry_reg [5];

    logic [31:0] num_c;
    logic [31:0] num1_reg, num2_reg, num3_reg, num4_reg;
    logic [55:0] plo1_reg, plo2_reg;
    logic [56:0] phi2_reg;
    logic [57:0] qsum;
    logic [31:0] qe3_reg, qe4_reg;
    logic [47:0] qd4_reg;
    logic [31:0] rem5;
    logic [31:0] z5_reg, z6_reg, z7_reg;

    logic signed [16:0] zl_s, zh_s;
    logic signed [47:0] lxl_reg, lxh_reg, lyl_reg, lyh_reg;
    logic signed [63:0] fx7_reg, fy7_reg;
    logic signed [63:0] adjx, adjy;
    logic signed [31:0] cam_reg [3];
    logic signed [63:0] pp_reg [3][3];
    logic signed [47:0] rr_reg [3][3];
    logic signed [31:0] tr_reg [3];
    logic signed [31:0] world_reg [3];

    assign adv  = !v_reg[NSTG-1] || out_ready;
    assign busy = |v_reg[NSTG-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NSTG-2:0], in_valid};
    end

    assign num_c = {smp.d, 16'b0} + HALF;
    assign qsum  = {1'b0, phi2_reg} + 58'(plo2_reg[55:24]);
    assign rem5  = num4_reg - qd4_reg[31:0];
    assign zl_s  = $signed({1'b0, z5_reg[15:0]});
    assign zh_s  = $signed({1'b0, z5_reg[31:16]});
    assign adjx  = fx7_reg + (fx7_reg[63] ? 64'sd524287 : 64'sd524288);
    assign adjy  = fy7_reg + (fy7_reg[63] ? 64'sd524287 : 64'sd524288);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= smp.side;
            for (int i = 1; i < NSTG; i++)
                side_reg[i] <= side_reg[i-1];
            rx_reg[0] <= smp.ratio_x;
            ry_reg[0] <= smp.ratio_y;
            for (int i = 1; i < 5; i++)
            begin
                rx_reg[i] <= rx_reg[i-1];
                ry_reg[i] <= ry_reg[i-1];
            end

            // z = round(d * 65536 / units), by reciprocal and one correction
            num1_reg <= num_c;
            plo1_reg <= 56'(num_c) * 56'(M_LO);
            num2_reg <= num1_reg;
            plo2_reg <= plo1_reg;
            phi2_reg <= 57'(num1_reg) * 57'(M_HI);
            num3_reg <= num2_reg;
            qe3_reg  <= qsum[55:24];
            num4_reg <= num3_reg;
            qe4_reg  <= qe3_reg;
            qd4_reg  <= 48'(qe3_reg) * 48'(DIV);
            z5_reg   <= (rem5 >= DIV) ? qe4_reg + 32'd1 : qe4_reg;

            // lateral offsets, ratio * z split on z halves
            lxl_reg <= 48'(rx_reg[4]) * 48'(zl_s);
            lxh_reg <= 48'(rx_reg[4]) * 48'(zh_s);
            lyl_reg <= 48'(ry_reg[4]) * 48'(zl_s);
            lyh_reg <= 48'(ry_reg[4]) * 48'(zh_s);
            z6_reg  <= z5_reg;
            fx7_reg <= 64'(lxl_reg) + (64'(lxh_reg) <<< 16);
            fy7_reg <= 64'(lyl_reg) + (64'(lyh_reg) <<< 16);
            z7_reg  <= z6_reg;
            cam_reg[0] <= sat32(adjx >>> 20);
            cam_reg[1] <= sat32(adjy >>> 20);
            cam_reg[2] <= z7_reg[31] ? 32'sh7FFF_FFFF : $signed(z7_reg);

            // pose transform
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pp_reg[r][c] <= 64'($signed(pose[r*4+c])) * 64'(cam_reg[c]);
                    rr_reg[r][c] <= 48'((pp_reg[r][c]
                        + (pp_reg[r][c][63] ? 64'sd32767 : 64'sd32768)) >>> 16);
                end
                tr_reg[r]    <= $signed(pose[r*4+3]);
                world_reg[r] <= sat32(64'(tr_reg[r]) + 64'(rr_reg[r][0])
                    + 64'(rr_reg[r][1]) + 64'(rr_reg[r][2]));
            end
        end
    end

    assign out_valid          = v_reg[NSTG-1];
    assign out_side           = side_reg[NSTG-1];
    assign out_item.world_x   = world_reg[0];
    assign out_item.world_y   = world_reg[1];
    assign out_item.world_z   = world_reg[2];
    assign out_item.out_red   = side_reg[NSTG-1].red;
    assign out_item.out_green = side_reg[NSTG-1].green;
    assign out_item.out_blue  = side_reg[NSTG-1].blue;

endmodule

[rtl/depth_ray_occupancy_sampler.sv]
// ----------------------------------------------------------------------------
// depth_ray_occupancy_sampler
// Back-projects depth pixels along camera rays and emits posed samples.
// ----------------------------------------------------------------------------
// Path: a kept pixel passes the bit-serial downsample remainder (skipped when
//   the factor is 0), then the ray-ratio states MUL, RND and LAUNCH, then the
//   point pipeline before its first sample appears.
// Throughput: one sample per cycle unless the output stalls. Pose loads and dead
//   pixels keep input ready; a dropped pixel blocks it until its remainder is
//   done; after a ray, input waits until its samples drain into the output register.
// Reset: config to defaults, pose to identity, pipeline empty.
module depth_ray_occupancy_sampler #(
    parameter int FRAME_WIDTH           = dros_pkg::FRAME_WIDTH_DEF,
    parameter int MAX_STEPS             = dros_pkg::MAX_STEPS_DEF,
    parameter int DEPTH_UNITS_PER_METRE = dros_pkg::DEPTH_UNITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_x, pixel_y, depth, red, green, blue, pose_index, pose_value, pad
    input  logic [dros_pkg::IN_DATA_W-1:0]      s_tdata,
    // action
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // world_x, world_y, world_z, out_red, out_green, out_blue
    output logic [dros_pkg::OUT_DATA_W-1:0]     m_tdata,
    // occupied, colour_valid
    output logic [dros_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dros_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dros_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dros_pkg::*;

    cfg_t      cfg_reg;
    pose_mat_t pose;
    ray_job_t  job;
    sample_t   smp;
    side_t     out_side;
    out_item_t out_item;

    logic job_launch;
    logic smp_valid;
    logic seq_busy;
    logic pipe_busy;
    logic adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_x          <= 14'd5120;
            cfg_reg.centre_y          <= 14'd3840;
            cfg_reg.inv_focal_x       <= 24'd31957;
            cfg_reg.inv_focal_y       <= 24'd31957;
            cfg_reg.ray_start         <= 16'd0;
            cfg_reg.ray_step          <= 16'd100;
            cfg_reg.ray_max           <= 16'd6400;
            cfg_reg.downsample_factor <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_CENTRE_X:    cfg_reg.centre_x          <= cfg_data[CENTRE_W-1:0];
                CFG_CENTRE_Y:    cfg_reg.centre_y          <= cfg_data[CENTRE_W-1:0];
                CFG_INV_FOCAL_X: cfg_reg.inv_focal_x       <= cfg_data[INVF_W-1:0];
                CFG_INV_FOCAL_Y: cfg_reg.inv_focal_y       <= cfg_data[INVF_W-1:0];
                CFG_RAY_START:   cfg_reg.ray_start         <= cfg_data[RAY_W-1:0];
                CFG_RAY_STEP:    cfg_reg.ray_step          <= cfg_data[RAY_W-1:0];
                CFG_RAY_MAX:     cfg_reg.ray_max           <= cfg_data[RAY_W-1:0];
                CFG_DOWNSAMPLE:  cfg_reg.downsample_factor <= cfg_data[RAY_W-1:0];
                default:         cfg_reg.ray_max           <= cfg_reg.ray_max;
            endcase
        end
    end

    dros_front #(
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_item     (in_item_t'(s_tdata)),
        .cfg         (cfg_reg),
        .engine_busy (seq_busy || pipe_busy),
        .pose        (pose),
        .job_launch  (job_launch),
        .job         (job)
    );

    dros_seq #(
        .MAX_STEPS (MAX_STEPS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .launch    (job_launch),
        .job       (job),
        .cfg       (cfg_reg),
        .adv       (adv),
        .smp_valid (smp_valid),
        .smp       (smp),
        .busy      (seq_busy)
    );

    dros_pipe #(
        .DEPTH_UNITS_PER_METRE (DEPTH_UNITS_PER_METRE)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smp_valid),
        .smp       (smp),
        .pose      (pose),
        .adv       (adv),
        .busy      (pipe_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .out_side  (out_side)
    );

    assign m_tdata = out_item;
    assign m_tuser = {out_side.colour_valid, out_side.occupied};
    assign m_tlast = out_side.last;

endmodule

[test/tb_depth_ray_occupancy_sampler.sv]
// ----------------------------------------------------------------------------
// tb_depth_ray_occupancy_sampler
// Drives pixel and pose-load items with random idling on both sides, predicts
// every ray sample in a local model and checks the output stream in order.
// ----------------------------------------------------------------------------
module tb_depth_ray_occupancy_sampler;
    timeunit 1ns;
    timeprecision 1ps;
    import dros_pkg::*;

    localparam int FW = 640;
    localparam int NSTEP = 64;
    localparam int DUNITS = 1000;

    typedef struct {
        logic [31:0] wx, wy, wz;
        logic        occ, cv, lst;
        logic [7:0]  r, g, b;
    } sample_exp_t;

    int errors = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    class sample_board;
        logic [13:0] cx, cy;
        logic [23:0] ifx, ify;
        logic [15:0] rstart, rstep, rmax, dsf;
        logic [31:0] pose [12];
        sample_exp_t pending[$];

        function new();
            cx = 5120; cy = 3840; ifx = 31957; ify = 31957;
            rstart = 0; rstep = 100; rmax = 6400; dsf = 1;
            foreach (pose[i]) pose[i] = 0;
            pose[0] = Q_ONE; pose[5] = Q_ONE; pose[10] = Q_ONE;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [23:0] v);
            case (idx)
                CFG_CENTRE_X:    cx = v[13:0];
                CFG_CENTRE_Y:    cy = v[13:0];
                CFG_INV_FOCAL_X: ifx = v;
                CFG_INV_FOCAL_Y: ify = v;
                CFG_RAY_START:   rstart = v[15:0];
                CFG_RAY_STEP:    rstep = v[15:0];
                CFG_RAY_MAX:     rmax = v[15:0];
                CFG_DOWNSAMPLE:  dsf = v[15:0];
            endcase
        endfunction

        function longint rnd_shift(longint v, int sh);
            longint half;
            half = longint'(1) <<< (sh - 1);
            if (v >= 0) return (v + half) >>> sh;
            return -(((-v) + half) >>> sh);
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint side_coord(longint pix, longint ctr, longint invf, longint z);
            longint ratio;
            ratio = rnd_shift((pix * 16 - ctr) * invf, 8);
            return clip32(rnd_shift(ratio * z, 20));
        endfunction

        function void note_item(action_t act, in_item_t it);
            longint lin, z, acc;
            longint cam [3];
            int n, d;
            bit crossed, occ, cv;
            sample_exp_t e;
            if (act == ACT_POSE) begin
                if (it.pose_index < 12) pose[it.pose_index] = it.pose_value;
                return;
            end
            if (it.depth == 0) return;
            lin = longint'(it.pixel_y) * FW + it.pixel_x;
            if (dsf != 0 && lin % dsf != 0) return;
            d = rstart;
            n = 0;
            crossed = 0;
            while (d < rmax && n < NSTEP) begin
                z = (longint'(d) * 65536 + DUNITS / 2) / DUNITS;
                cam[0] = side_coord(it.pixel_x, cx, ifx, z);
                cam[1] = side_coord(it.pixel_y, cy, ify, z);
                cam[2] = clip32(z);
                occ = d > it.depth;
                cv = occ && !crossed;
                if (occ) crossed = 1;
                for (int r = 0; r < 3; r++)
                begin
                    acc = longint'($signed(pose[r*4+3]));
                    for (int c = 0; c < 3; c++)
                        acc += rnd_shift(longint'($signed(pose[r*4+c])) * cam[c], 16);
                    acc = clip32(acc);
                    if (r == 0) e.wx = acc[31:0];
                    else if (r == 1) e.wy = acc[31:0];
                    else e.wz = acc[31:0];
                end
                e.occ = occ; e.cv = cv; e.lst = 0;
                e.r = cv ? it.red : 8'd0;
                e.g = cv ? it.green : 8'd0;
                e.b = cv ? it.blue : 8'd0;
                pending = {pending, e};
                n++;
                d += rstep;
            end
            if (n > 0) pending[pending.size() - 1].lst = 1;
        endfunction

        task check_sample(out_item_t o, logic [1:0] u, logic l);
            sample_exp_t e;
            if (pending.size() == 0) begin
                report("unexpected sample");
                return;
            end
            e = pending.pop_front();
            if (o.world_x !== e.wx) report($sformatf("world_x %h exp %h", o.world_x, e.wx));
            if (o.world_y !== e.wy) report($sformatf("world_y %h exp %h", o.world_y, e.wy));
            if (o.world_z !== e.wz) report($sformatf("world_z %h exp %h", o.world_z, e.wz));
            if (u[0] !== e.occ) report("occupied");
            if (u[1] !== e.cv) report("colour_valid");
            if (l !== e.lst) report("last");
            if (o.out_red !== e.r || o.out_green !== e.g || o.out_blue !== e.b)
                report("colour");
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0, s_tready, s_tuser = 0;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0, m_tlast;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic cfg_valid = 0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    bit stim_done = 0;
    bit recv_quiet = 0;
    int rx_wait = 0;
    sample_board sb = new();

    depth_ray_occupancy_sampler dut (.*);

    always #6 clk = ~clk;

    task automatic write_reg(cfg_reg_t idx, logic [23:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    // valid stays up after an accept; the next item, its idle gap or drain() ends it
    task automatic send_item(action_t act, in_item_t it);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= IN_DATA_W'(it);
        do @(posedge clk); while (!s_tready);
        sb.note_item(act, it);
    endtask

    task automatic send_pixel(int x, int y, int dep, bit junk);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom});
        it.pad = 0;
        it.pixel_x = PX_W'(x); it.pixel_y = PY_W'(y); it.depth = DEPTH_W'(dep);
        if (!junk) begin
            it.pose_index = 0; it.pose_value = 0;
        end
        send_item(ACT_PIXEL, it);
    endtask

    task automatic send_pose(int idx, logic [31:0] v);
        in_item_t it;
        it = '0;
        it.pixel_x = PX_W'($urandom); it.depth = DEPTH_W'($urandom);
        it.pose_index = PIDX_W'(idx); it.pose_value = v;
        send_item(ACT_POSE, it);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_items(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_pose($urandom_range(0, 15), $urandom_range(0, 3) == 0 ? $urandom
                          : $urandom_range(0, 32'h20000) - 32'h10000);
            else
                send_pixel($urandom_range(0, 1023), $urandom_range(0, 511),
                           $urandom_range(0, 9) == 0 ? 0 : $urandom_range(0, 65535),
                           $urandom_range(0, 1));
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check_sample(out_item_t'(m_tdata), m_tuser, m_tlast);
            rx_wait = recv_quiet ? 0 : $urandom_range(0, 11);
        end
        else if (rx_wait > 0)
            rx_wait--;
        m_tready <= (rx_wait == 0);
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_pixel(0, 0, 3000, 0);
        send_pixel(639, 479, 65535, 1);
        send_pixel(1023, 511, 1, 1);
        send_pixel(320, 240, 0, 0);
        send_pose(0, 32'h8000_0000);
        send_pose(3, 32'h7FFF_FFFF);
        send_pose(7, 32'hFFFF_0000);
        send_pose(11, 32'h0002_0000);
        send_pose(12, 32'h1234_5678);
        send_pose(15, 32'hFFFF_FFFF);
        send_pixel(100, 50, 2000, 0);
        drain();
        write_reg(CFG_CENTRE_X, 14'h3FFF);
        write_reg(CFG_CENTRE_Y, 0);
        write_reg(CFG_INV_FOCAL_X, 24'hFFFFFF);
        write_reg(CFG_INV_FOCAL_Y, 0);
        write_reg(CFG_RAY_START, 500);
        write_reg(CFG_RAY_STEP, 0);
        write_reg(CFG_RAY_MAX, 65535);
        write_reg(CFG_DOWNSAMPLE, 0);
        send_pixel(0, 0, 400, 0);
        send_pixel(1023, 511, 65535, 1);
        drain();
        write_reg(CFG_RAY_STEP, 65535);
        write_reg(CFG_RAY_START, 65534);
        send_pixel(5, 5, 7, 0);
        drain();
        write_reg(CFG_RAY_START, 0);
        write_reg(CFG_RAY_STEP, 1);
        write_reg(CFG_RAY_MAX, 0);
        send_pixel(5, 5, 7, 0);
        drain();
        write_reg(CFG_RAY_MAX, 10);
        write_reg(CFG_DOWNSAMPLE, 65535);
        send_pixel(0, 0, 4, 0);
        send_pixel(255, 102, 4, 0);
        send_pixel(1, 0, 4, 0);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_CENTRE_X, $urandom_range(0, 16383));
            write_reg(CFG_CENTRE_Y, $urandom_range(0, 16383));
            write_reg(CFG_INV_FOCAL_X, ph == 0 ? 31957 : $urandom_range(0, 24'hFFFFFF));
            write_reg(CFG_INV_FOCAL_Y, ph == 0 ? 31957 : $urandom_range(0, 24'hFFFFFF));
            write_reg(CFG_RAY_START, $urandom_range(0, 3000));
            write_reg(CFG_RAY_STEP, ph == 3 ? $urandom_range(1, 65535) : $urandom_range(1, 300));
            write_reg(CFG_RAY_MAX, $urandom_range(0, 65535));
            write_reg(CFG_DOWNSAMPLE, ph < 2 ? ph : $urandom_range(1, 4));
            recv_quiet <= (ph == 2);
            random_items(60);
            drain();
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        if (errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

[files.f]
rtl/dros_pkg.sv
rtl/dros_mod_unit.sv
rtl/dros_front.sv
rtl/dros_seq.sv
rtl/dros_pipe.sv
rtl/depth_ray_occupancy_sampler.sv
test/tb_depth_ray_occupancy_sampler.sv
